[rtl/serial_frame_receiver_crc16_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame receiver
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Same-cycle implication
`define SFRC_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication
`define SFRC_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

[rtl/sfrc_pkg.sv]
// ----------------------------------------------------------------------------
// sfrc_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package sfrc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hBB;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_FRAMING = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_BAD     = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 1'b0,
    REG_HEADER_SECOND = 1'b1
  } cfg_reg_t;

endpackage

[rtl/sfrc_crc_byte.sv]
// ----------------------------------------------------------------------------
// sfrc_crc_byte
// CRC-16/MODBUS update by one byte, reflected, all eight bit steps in one pass.
// ----------------------------------------------------------------------------
module sfrc_crc_byte (
  input  logic [sfrc_pkg::CRC_W-1:0]  crc_in,
  input  logic [sfrc_pkg::BYTE_W-1:0] data_in,
  output logic [sfrc_pkg::CRC_W-1:0]  crc_out
);
  import sfrc_pkg::*;

  // Fold the byte in, then shift out eight bits LSB first
  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

[rtl/serial_frame_receiver_crc16.sv]
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16
// Length-prefixed frame receiver with CRC-16/MODBUS check, one byte per item.
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns exactly one result item for it:
// framing byte taken, payload byte (with its index, last flag and frame
// length), frame good, CRC mismatch, or header byte rejected. A frame is two
// header bytes (cfg index 0 and 1, reset 0x55 and 0xBB), a length byte, that
// many payload bytes, then the CRC sent low byte first; the CRC covers header,
// length and payload. Throughput is one item per clock while the result channel
// does not stall; an accepted item passes through the input register, then the
// result register, and the per-cycle limit is the combinational CRC byte update.
// Configure the header registers only while the block is idle.
module serial_frame_receiver_crc16 (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfrc_pkg::BYTE_W-1:0]  cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sfrc_pkg::BYTE_W-1:0]  in_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_kind,
  output logic [sfrc_pkg::BYTE_W-1:0]  out_data_byte,
  output logic [sfrc_pkg::BYTE_W-1:0]  out_byte_index,
  output logic                         out_is_last_payload,
  output logic [sfrc_pkg::BYTE_W-1:0]  out_frame_length
);
  import sfrc_pkg::*;
  `include "serial_frame_receiver_crc16_assert.svh"

  // Configuration registers
  logic [BYTE_W-1:0] hdr_first_r;
  logic [BYTE_W-1:0] hdr_second_r;

  // Input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] byte_r;

  // Frame state
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [BYTE_W-1:0] len_r,    len_nxt;
  logic [CRC_W-1:0]  crc_r,    crc_nxt;
  logic [BYTE_W-1:0] crc_lo_r, crc_lo_nxt;

  // Result register
  logic              out_vld_r;
  kind_t             kind_r,   kind_nxt;
  logic [BYTE_W-1:0] data_r,   data_nxt;
  logic [BYTE_W-1:0] idx_r,    idx_nxt;
  logic              last_r,   last_nxt;
  logic [BYTE_W-1:0] flen_r,   flen_nxt;

  logic              advance;
  logic [CRC_W-1:0]  crc_fed;
  logic [POS_W-1:0]  end_pos;
  logic [POS_W-1:0]  pay_off;
  logic [BYTE_W-1:0] want;
  logic [CRC_W-1:0]  crc_got;

  // Move the held item into the result register when it is free or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HEADER_FIRST_RST;
      hdr_second_r <= HEADER_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER_FIRST:  hdr_first_r  <= cfg_wdata;
        REG_HEADER_SECOND: hdr_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
    end
  end

  sfrc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (byte_r),
    .crc_out (crc_fed)
  );

  assign end_pos = {1'b0, len_r} + POS_W'(3);
  assign pay_off = pos_r - POS_W'(3);
  assign want    = (pos_r == POS_W'(0)) ? hdr_first_r : hdr_second_r;
  assign crc_got = {byte_r, crc_lo_r};

  // Decode the byte against the frame position
  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    kind_nxt   = KIND_FRAMING;
    data_nxt   = '0;
    idx_nxt    = '0;
    last_nxt   = 1'b0;
    flen_nxt   = '0;
    priority if (pos_r == POS_W'(0) || pos_r == POS_W'(1)) begin
      if (byte_r == want) begin
        crc_nxt = crc_fed;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        kind_nxt   = KIND_REJECT;
        pos_nxt    = '0;
        len_nxt    = '0;
        crc_nxt    = CRC_INIT;
        crc_lo_nxt = '0;
      end
    end else if (pos_r == POS_W'(2)) begin
      len_nxt  = byte_r;
      crc_nxt  = crc_fed;
      flen_nxt = byte_r;
      pos_nxt  = POS_W'(3);
    end else if (pos_r < end_pos) begin
      kind_nxt = KIND_PAYLOAD;
      data_nxt = byte_r;
      idx_nxt  = pay_off[BYTE_W-1:0];
      last_nxt = (pos_r + POS_W'(1)) == end_pos;
      flen_nxt = len_r;
      crc_nxt  = crc_fed;
      pos_nxt  = pos_r + POS_W'(1);
    end else if (pos_r == end_pos) begin
      crc_lo_nxt = byte_r;
      flen_nxt   = len_r;
      pos_nxt    = pos_r + POS_W'(1);
    end else begin
      kind_nxt   = (crc_got == crc_r) ? KIND_GOOD : KIND_BAD;
      flen_nxt   = len_r;
      pos_nxt    = '0;
      len_nxt    = '0;
      crc_nxt    = CRC_INIT;
      crc_lo_nxt = '0;
    end
  end

  // Advance frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      crc_r    <= CRC_INIT;
      crc_lo_r <= '0;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Hold or load the result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
      flen_r <= flen_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_kind            = kind_r;
  assign out_data_byte       = data_r;
  assign out_byte_index      = idx_r;
  assign out_is_last_payload = last_r;
  assign out_frame_length    = flen_r;

  // Checks
  `SFRC_ASSERT_NOW(a_nonpayload_clear,
    out_vld_r && kind_r != KIND_PAYLOAD,
    data_r == '0 && idx_r == '0 && !last_r,
    "non-payload result carries payload fields")
  `SFRC_ASSERT_NOW(a_last_matches_len,
    out_vld_r && last_r,
    kind_r == KIND_PAYLOAD && (idx_r + BYTE_W'(1)) == flen_r,
    "last flag disagrees with frame length")
  `SFRC_ASSERT_NEXT(a_end_rehunts,
    advance && (kind_nxt == KIND_GOOD || kind_nxt == KIND_BAD || kind_nxt == KIND_REJECT),
    pos_r == '0 && crc_r == CRC_INIT && len_r == '0,
    "state not returned to hunting after frame end or reject")
  `SFRC_ASSERT_NOW(a_pos_bound,
    1'b1,
    pos_r <= end_pos + POS_W'(1),
    "frame position beyond CRC high byte")

endmodule

[sim/tb_serial_frame_receiver_crc16.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for serial_frame_receiver_crc16
// Drives received bytes through the deframer and checks every result item
// against a cycle-free predictor of the frame parser and its CRC-16/MODBUS.
// Directed frames come first: empty, short and full-length payloads, a bad
// CRC and header rejects. Random phases follow under several header settings
// and idle patterns, then a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver_crc16;
  import sfrc_pkg::*;

  localparam int LATENCY      = 2;
  localparam int TAIL_CYCLES  = 2 * LATENCY + 6;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int RANDOM_ITEMS = 35;
  localparam int PRINT_CAP    = 40;
  localparam int LIMIT_NS     = 5_000_000;

  typedef logic [BYTE_W-1:0] byte_queue_t[$];

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] idx;
    logic              last;
    logic [BYTE_W-1:0] flen;
  } frame_result_t;

  // Clock, reset and block inputs, all known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER_FIRST;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_stall = 1'b0;

  logic                 in_stall;
  logic                 out_valid;
  logic [2:0]           out_kind;
  logic [BYTE_W-1:0]    out_data_byte;
  logic [BYTE_W-1:0]    out_byte_index;
  logic                 out_is_last_payload;
  logic [BYTE_W-1:0]    out_frame_length;

  // Predictor state and its copy of the header registers
  logic [POS_W-1:0]     rx_pos;
  logic [BYTE_W-1:0]    rx_len;
  logic [CRC_W-1:0]     rx_crc;
  logic [BYTE_W-1:0]    rx_crc_lo;
  logic [BYTE_W-1:0]    hdr_first  = HEADER_FIRST_RST;
  logic [BYTE_W-1:0]    hdr_second = HEADER_SECOND_RST;

  frame_result_t        pending_results[$];
  int                   mismatches    = 0;
  int                   items_sent    = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct     = 0;
  int                   hold_seq      = 0;
  int                   hold_seen     = 0;
  int                   hold_left     = 0;

  serial_frame_receiver_crc16 DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_byte_index      (out_byte_index),
    .out_is_last_payload (out_is_last_payload),
    .out_frame_length    (out_frame_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  // One byte through the reflected CRC-16, LSB first
  function automatic logic [CRC_W-1:0] crc16_modbus_byte(input logic [CRC_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void go_hunt();
    rx_pos    = '0;
    rx_len    = '0;
    rx_crc    = CRC_INIT;
    rx_crc_lo = '0;
  endfunction

  // Advance the parser by one accepted byte and queue the result it causes
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    int            pos;
    int            len;
    r      = '0;
    r.kind = KIND_FRAMING;
    pos    = rx_pos;
    len    = rx_len;
    if (pos <= 1) begin
      if (b == ((pos == 0) ? hdr_first : hdr_second)) begin
        rx_crc = crc16_modbus_byte(rx_crc, b);
        rx_pos = rx_pos + 1'b1;
      end else begin
        r.kind = KIND_REJECT;
        go_hunt();
      end
    end else if (pos == 2) begin
      rx_len = b;
      rx_crc = crc16_modbus_byte(rx_crc, b);
      r.flen = b;
      rx_pos = 3;
    end else if (pos < 3 + len) begin
      r.kind = KIND_PAYLOAD;
      r.data = b;
      r.idx  = 8'(pos - 3);
      r.last = (pos - 2 == len);
      r.flen = rx_len;
      rx_crc = crc16_modbus_byte(rx_crc, b);
      rx_pos = rx_pos + 1'b1;
    end else if (pos == 3 + len) begin
      rx_crc_lo = b;
      r.flen    = rx_len;
      rx_pos    = rx_pos + 1'b1;
    end else begin
      r.kind = ({b, rx_crc_lo} == rx_crc) ? KIND_GOOD : KIND_BAD;
      r.flen = rx_len;
      go_hunt();
    end
    pending_results = {pending_results, r};
  endtask

  // Offer one item after a random gap and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    deframe_byte(b);
  endtask

  // Send a complete frame with the current headers, CRC optionally corrupted
  task automatic send_frame(input byte_queue_t body, input bit corrupt);
    logic [CRC_W-1:0] crc;
    crc = crc16_modbus_byte(CRC_INIT, hdr_first);
    send_byte(hdr_first);
    crc = crc16_modbus_byte(crc, hdr_second);
    send_byte(hdr_second);
    crc = crc16_modbus_byte(crc, 8'(body.size()));
    send_byte(8'(body.size()));
    foreach (body[i]) begin
      crc = crc16_modbus_byte(crc, body[i]);
      send_byte(body[i]);
    end
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(15));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  function automatic byte_queue_t random_body(input int len);
    byte_queue_t q;
    for (int i = 0; i < len; i++) q = {q, 8'($urandom)};
    return q;
  endfunction

  // Drop valid, wait for every expected item, then let the pipeline settle
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
      pending_results.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_header(input cfg_reg_t sel, input logic [BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (sel)
      REG_HEADER_FIRST:  hdr_first  = value;
      REG_HEADER_SECOND: hdr_second = value;
      default: ;
    endcase
  endtask

  // Empty frame, two-byte frame with extreme payload, empty frame with bad CRC
  task automatic test_reset_frames();
    byte_queue_t body;
    send_idle_pct = 0;
    stall_pct     = 0;
    body.delete();
    send_frame(body, 1'b0);
    body = {body, 8'h00};
    body = {body, 8'hFF};
    send_frame(body, 1'b0);
    body.delete();
    send_frame(body, 1'b1);
  endtask

  // Wrong first byte, wrong second byte, and the dropped byte not retried
  task automatic test_header_rejects();
    send_byte(8'h12);
    send_byte(hdr_first);
    send_byte(hdr_first);
    send_byte(hdr_second);
  endtask

  task automatic test_max_length();
    send_frame(random_body(255), 1'b0);
  endtask

  task automatic run_random_phase(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2,
                                  input int idle_pct, input int rx_pct);
    int          start;
    int          pick;
    int          len;
    byte_queue_t body;
    drain_results();
    write_header(REG_HEADER_FIRST, h1);
    write_header(REG_HEADER_SECOND, h2);
    send_idle_pct = idle_pct;
    stall_pct     = rx_pct;
    start         = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(8);
        send_frame(random_body(len), $urandom_range(4) == 0);
      end else if (pick < 85) begin
        send_byte(8'($urandom));
      end else if (pick < 92) begin
        // good first header, wrong second
        send_byte(hdr_first);
        send_byte(hdr_second ^ 8'($urandom_range(1, 255)));
      end else if (pick < 96) begin
        send_byte(hdr_first);
        send_byte(hdr_first);
      end else begin
        // truncated frame: the bytes that follow are swallowed as its tail
        len = $urandom_range(2, 6);
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(8'(len));
        body = random_body($urandom_range(1, len - 1));
        foreach (body[i]) send_byte(body[i]);
      end
    end
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_input_backpressure();
    drain_results();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_seq <= hold_seq + 1;
    repeat (3) send_frame(random_body($urandom_range(2, 6)), 1'b0);
  endtask

  // Count the long hold-off in cycles
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each accepted result against the oldest expectation, then pick stall
  always @(posedge clk) begin : result_checker
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = kind_t'(out_kind);
      got.data = out_data_byte;
      got.idx  = out_byte_index;
      got.last = out_is_last_payload;
      got.flen = out_frame_length;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_kind));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.data !== want.data)
          report_mismatch($sformatf("data_byte %0h, want %0h", got.data, want.data));
        if (got.idx !== want.idx)
          report_mismatch($sformatf("byte_index %0d, want %0d", got.idx, want.idx));
        if (got.last !== want.last)
          report_mismatch($sformatf("is_last_payload %0b, want %0b", got.last, want.last));
        if (got.flen !== want.flen)
          report_mismatch($sformatf("frame_length %0d, want %0d", got.flen, want.flen));
      end
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  initial begin
    go_hunt();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_frames();
    test_header_rejects();
    test_max_length();
    run_random_phase(8'h00, 8'hFF, 0, 0);
    run_random_phase(8'hFF, 8'h00, 73, 0);
    run_random_phase(8'($urandom), 8'($urandom), 0, 73);
    run_random_phase(HEADER_FIRST_RST, HEADER_SECOND_RST, 6, 6);
    test_input_backpressure();
    drain_results();

    if (mismatches == 0) begin
      $display("[serial_frame_receiver_crc16] OK");
    end else begin
      $display("[serial_frame_receiver_crc16] ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(LIMIT_NS);
    $display("[serial_frame_receiver_crc16] ERROR");
    $finish;
  end

endmodule

[serial_frame_receiver_crc16.f]
+incdir+rtl
rtl/sfrc_pkg.sv
rtl/sfrc_crc_byte.sv
rtl/serial_frame_receiver_crc16.sv
sim/tb_serial_frame_receiver_crc16.sv
